// ===== sv/gbl_pkg.sv =====
`default_nettype none
package gbl_pkg;

  // store depths
  localparam int MAX_FREQ_POINTS = 64;
  localparam int MAX_ALT_POINTS  = 32;
  localparam int GRID_DEPTH      = MAX_FREQ_POINTS * MAX_ALT_POINTS;

  // input beat kinds
  localparam logic [1:0] KIND_FREQ  = 2'd0;
  localparam logic [1:0] KIND_ALT   = 2'd1;
  localparam logic [1:0] KIND_CELL  = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NOT_LOADED = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE    = 2'd2;

  // configuration register indexes
  localparam logic CFG_FREQ_POINTS = 1'b0;
  localparam logic CFG_ALT_POINTS  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_DIV_INIT,
    ST_DIV,
    ST_ADDR,
    ST_CELL,
    ST_BLEND,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== sv/grid_bilinear_lookup.sv =====
// Table writes (freq point, alt point, cell) are taken one per cycle, back to back, while idle.
// A query runs a linear scan of each axis memory at one entry per cycle, up to two
// 16-step restoring divisions, four grid reads and six passes through one shared
// 17x32 multiplier. Not-loaded queries go from idle straight to the result.
// One query is in flight at a time; the result sits in an output register.
// rst (synchronous) clears the count registers and control; tables are undefined.
`default_nettype none
module grid_bilinear_lookup
  import gbl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [10:0] entry_index,
  input  wire logic [31:0] entry_value,
  input  wire logic [23:0] query_freq,
  input  wire logic [15:0] query_alt,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      attenuation,
  output logic [1:0]       status
);

  state_t state, state_next;

  // configuration
  logic [6:0] freq_points;
  logic [5:0] alt_points;

  // captured query
  logic [23:0] qf;
  logic [15:0] qa;
  logic [6:0]  nf;
  logic [5:0]  na;
  logic [1:0]  res_status;

  // axis scan
  logic        ax;
  logic [6:0]  cnt;
  logic        rd_vld;
  logic [6:0]  rd_idx;
  logic [23:0] a0, a1, alast, bval, nxt;
  logic [6:0]  best;
  logic        just_set;

  // bracket results
  logic [5:0]  fi, fn;
  logic [4:0]  ai, an;
  logic [23:0] f_v0, f_v1;
  logic [15:0] a_v0, a_v1;
  logic        oob_f;

  // divider
  logic        dsel;
  logic [23:0] rem, den;
  logic [15:0] quo;
  logic [3:0]  dcnt;
  logic [15:0] tf, th;

  // grid fetch and blend
  logic [10:0] row0, row1;
  logic [2:0]  cc;
  logic        cell_vld;
  logic [1:0]  cell_idx;
  logic [31:0] cval [4];
  logic [2:0]  step;
  logic [48:0] acc;
  logic [31:0] r0, r1;

  // memories
  logic [23:0] freq_mem [MAX_FREQ_POINTS];
  logic [15:0] alt_mem  [MAX_ALT_POINTS];
  logic [31:0] grid_mem [GRID_DEPTH];
  logic [23:0] freq_rd;
  logic [15:0] alt_rd;
  logic [31:0] grid_rd;

  // control decode
  logic        acc_beat, is_query, empty_tbl, scan_end, out_load;
  logic [6:0]  n_cur;
  logic [23:0] x_cur, d_cur;

  // resolve
  logic [6:0]  lo_c, hi_c;
  logic [23:0] v0_c, v1_c;
  logic        oob_c;

  // divider datapath
  logic [23:0] x_d, x0_d, x1_d;
  logic        zero_d;
  logic [24:0] r2, sub;
  logic        ge;

  // multiplier datapath
  logic [11:0] p0, p1;
  logic [10:0] gaddr;
  logic [16:0] mul_a;
  logic [31:0] mul_b;
  logic [48:0] prod;

  assign acc_beat  = in_valid && !in_stall;
  assign is_query  = (kind == KIND_QUERY);
  assign empty_tbl = (freq_points == 7'd0) || (alt_points == 6'd0);
  assign n_cur     = ax ? {1'b0, na} : nf;
  assign x_cur     = ax ? {8'd0, qa} : qf;
  assign d_cur     = ax ? {8'd0, alt_rd} : freq_rd;
  assign scan_end  = rd_vld && (rd_idx == n_cur - 7'd1);

  // bracket decision once the scan is through
  always_comb begin
    oob_c = (x_cur < a0) || (x_cur > alast);
    if (x_cur <= a0) begin
      lo_c = 7'd0;
      v0_c = a0;
      v1_c = (n_cur > 7'd1) ? a1 : a0;
    end else if (x_cur >= alast) begin
      lo_c = n_cur - 7'd1;
      v0_c = alast;
      v1_c = alast;
    end else begin
      lo_c = best;
      v0_c = bval;
      v1_c = nxt;
    end
    hi_c = (lo_c + 7'd1 < n_cur) ? lo_c + 7'd1 : n_cur - 7'd1;
  end

  // divider operands and one restoring step
  assign x_d    = dsel ? {8'd0, qa} : qf;
  assign x0_d   = dsel ? {8'd0, a_v0} : f_v0;
  assign x1_d   = dsel ? {8'd0, a_v1} : f_v1;
  assign zero_d = (x1_d <= x0_d) || (x_d <= x0_d);
  assign r2     = {rem, 1'b0};
  assign ge     = (r2 >= {1'b0, den});
  assign sub    = r2 - {1'b0, den};

  // row bases and cell address
  assign p0 = {6'd0, fi} * {6'd0, na};
  assign p1 = {6'd0, fn} * {6'd0, na};
  always_comb begin
    case (cc[1:0])
      2'd0:    gaddr = row0 + {6'd0, ai};
      2'd1:    gaddr = row0 + {6'd0, an};
      2'd2:    gaddr = row1 + {6'd0, ai};
      default: gaddr = row1 + {6'd0, an};
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (step)
      3'd0:    begin mul_a = 17'h10000 - {1'b0, th}; mul_b = cval[0]; end
      3'd1:    begin mul_a = {1'b0, th};             mul_b = cval[1]; end
      3'd2:    begin mul_a = 17'h10000 - {1'b0, th}; mul_b = cval[2]; end
      3'd3:    begin mul_a = {1'b0, th};             mul_b = cval[3]; end
      3'd4:    begin mul_a = 17'h10000 - {1'b0, tf}; mul_b = r0;      end
      default: begin mul_a = {1'b0, tf};             mul_b = r1;      end
    endcase
  end
  assign prod = {32'd0, mul_a} * {17'd0, mul_b};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:
        if (in_valid && is_query) state_next = empty_tbl ? ST_FIN : ST_SCAN;
      ST_SCAN:
        if (scan_end) state_next = ST_RESOLVE;
      ST_RESOLVE:
        if (!ax) state_next = ST_SCAN;
        else if (oob_f || oob_c) state_next = ST_FIN;
        else state_next = ST_DIV_INIT;
      ST_DIV_INIT:
        if (!zero_d) state_next = ST_DIV;
        else if (dsel) state_next = ST_ADDR;
      ST_DIV:
        if (dcnt == 4'd15) state_next = dsel ? ST_ADDR : ST_DIV_INIT;
      ST_ADDR:
        state_next = ST_CELL;
      ST_CELL:
        if (cc == 3'd4) state_next = ST_BLEND;
      ST_BLEND:
        if (step == 3'd5) state_next = ST_FIN;
      ST_FIN:
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:
        state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_FIN:  out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      freq_points <= 7'd0;
      alt_points  <= 6'd0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == CFG_FREQ_POINTS) freq_points <= cfg_data;
        else alt_points <= cfg_data[5:0];
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // memories: write on accepted beats, registered reads
  always_ff @(posedge clk) begin
    if (acc_beat && kind == KIND_FREQ && entry_index[10:6] == 5'd0)
      freq_mem[entry_index[5:0]] <= entry_value[23:0];
    if (acc_beat && kind == KIND_ALT && entry_index[10:5] == 6'd0)
      alt_mem[entry_index[4:0]] <= entry_value[15:0];
    if (acc_beat && kind == KIND_CELL)
      grid_mem[entry_index] <= entry_value;
    freq_rd <= freq_mem[cnt[5:0]];
    alt_rd  <= alt_mem[cnt[4:0]];
    grid_rd <= grid_mem[gaddr];
  end

  // datapath
  always_ff @(posedge clk) begin
    cell_vld <= 1'b0;
    rd_vld   <= 1'b0;
    unique case (state)
      ST_IDLE: begin
        qf         <= query_freq;
        qa         <= query_alt;
        nf         <= (freq_points > 7'(MAX_FREQ_POINTS)) ? 7'(MAX_FREQ_POINTS) : freq_points;
        na         <= (alt_points > 6'(MAX_ALT_POINTS)) ? 6'(MAX_ALT_POINTS) : alt_points;
        res_status <= STAT_NOT_LOADED;
        ax         <= 1'b0;
        cnt        <= 7'd0;
        best       <= 7'd0;
        just_set   <= 1'b0;
        dsel       <= 1'b0;
      end
      ST_SCAN: begin
        // issue one read, handle the beat that returned
        rd_vld <= (cnt < n_cur);
        rd_idx <= cnt;
        cnt    <= cnt + 7'd1;
        if (rd_vld) begin
          if (rd_idx == 7'd0) a0 <= d_cur;
          if (rd_idx == 7'd1) a1 <= d_cur;
          if (rd_idx == n_cur - 7'd1) alast <= d_cur;
          if (just_set) nxt <= d_cur;
          if (rd_idx < n_cur - 7'd1 && d_cur <= x_cur) begin
            best     <= rd_idx;
            bval     <= d_cur;
            just_set <= 1'b1;
          end else begin
            just_set <= 1'b0;
          end
        end
      end
      ST_RESOLVE: begin
        cnt      <= 7'd0;
        best     <= 7'd0;
        just_set <= 1'b0;
        ax       <= 1'b1;
        if (!ax) begin
          fi    <= lo_c[5:0];
          fn    <= hi_c[5:0];
          f_v0  <= v0_c;
          f_v1  <= v1_c;
          oob_f <= oob_c;
        end else begin
          ai         <= lo_c[4:0];
          an         <= hi_c[4:0];
          a_v0       <= v0_c[15:0];
          a_v1       <= v1_c[15:0];
          res_status <= (oob_f || oob_c) ? STAT_OUTSIDE : STAT_OK;
        end
      end
      ST_DIV_INIT: begin
        rem  <= x_d - x0_d;
        den  <= x1_d - x0_d;
        quo  <= 16'd0;
        dcnt <= 4'd0;
        if (zero_d) begin
          if (dsel) th <= 16'd0;
          else tf <= 16'd0;
          dsel <= 1'b1;
        end
      end
      ST_DIV: begin
        rem  <= ge ? sub[23:0] : r2[23:0];
        quo  <= {quo[14:0], ge};
        dcnt <= dcnt + 4'd1;
        if (dcnt == 4'd15) begin
          if (dsel) th <= {quo[14:0], ge};
          else tf <= {quo[14:0], ge};
          dsel <= 1'b1;
        end
      end
      ST_ADDR: begin
        row0 <= p0[10:0];
        row1 <= p1[10:0];
        cc   <= 3'd0;
      end
      ST_CELL: begin
        cell_vld <= (cc < 3'd4);
        cell_idx <= cc[1:0];
        cc       <= cc + 3'd1;
        step     <= 3'd0;
      end
      ST_BLEND: begin
        acc  <= step[0] ? acc + prod : prod;
        step <= step + 3'd1;
        if (step == 3'd2) r0 <= acc[47:16];
        if (step == 3'd4) r1 <= acc[47:16];
      end
      ST_FIN: begin
        if (out_load) begin
          status      <= res_status;
          attenuation <= (res_status == STAT_OK) ? acc[47:16] : 32'd0;
        end
      end
      default: ;
    endcase
    if (cell_vld) cval[cell_idx] <= grid_rd;
  end

  // checks
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < den)
    else $error("divider remainder not below divisor");

  a_bracket: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADDR |-> ({1'b0, fn} < nf) && (fi <= fn) && ({1'b0, an} < na) && (ai <= an))
    else $error("bracket index out of order");

  a_blend_cells: assert property (@(posedge clk) disable iff (rst)
    state == ST_BLEND |-> cc == 3'd5)
    else $error("blend started before all cells arrived");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    $past(out_load) && status != STAT_OK |-> attenuation == 32'd0)
    else $error("refused query returned nonzero attenuation");

endmodule
`default_nettype wire

// ===== tb/sv/gbl_checker.sv =====
module gbl_checker
  import gbl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [10:0] entry_index,
  input  wire logic [31:0] entry_value,
  input  wire logic [23:0] query_freq,
  input  wire logic [15:0] query_alt,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] attenuation,
  input  wire logic [1:0]  status,
  output int               failures,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] atten;
    logic [1:0]  stat;
  } lookup_t;

  // shadow copy of the tables and counts
  logic [23:0] freq_ax [MAX_FREQ_POINTS];
  logic [23:0] alt_ax [MAX_ALT_POINTS];
  logic [31:0] grid [GRID_DEPTH];
  logic [6:0]  freq_cnt;
  logic [5:0]  alt_cnt;
  lookup_t     expected_q [$];

  assign pending = expected_q.size();

  initial failures = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    failures++;
  endtask

  function automatic logic [23:0] ax_at(input bit on_alt, input int i);
    return on_alt ? alt_ax[i] : freq_ax[i];
  endfunction

  // lower bracket index on one axis
  function automatic int bracket(input bit on_alt, input int n, input logic [23:0] x);
    int best;
    best = 0;
    if (x <= ax_at(on_alt, 0)) return 0;
    if (x >= ax_at(on_alt, n - 1)) return n - 1;
    for (int i = 0; i + 1 < n; i++) begin
      if (ax_at(on_alt, i) <= x) best = i;
    end
    return best;
  endfunction

  function automatic logic [15:0] frac(input logic [23:0] x, input logic [23:0] x0,
                                       input logic [23:0] x1);
    logic [63:0] t;
    if (x1 <= x0 || x <= x0) return 16'd0;
    t = (64'(x - x0) << 16) / 64'(x1 - x0);
    return (t > 64'd65535) ? 16'hFFFF : t[15:0];
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] lo, input logic [31:0] hi,
                                        input logic [15:0] t);
    logic [63:0] s;
    s = 64'(17'd65536 - 17'(t)) * 64'(lo) + 64'(t) * 64'(hi);
    return s[47:16];
  endfunction

  function automatic lookup_t lookup(input logic [23:0] qf, input logic [15:0] qa);
    int nf, na, fi, ai, fn, an;
    logic [15:0] tf, th;
    logic [31:0] r0, r1;
    lookup_t r;
    nf = (freq_cnt > MAX_FREQ_POINTS) ? MAX_FREQ_POINTS : int'(freq_cnt);
    na = (alt_cnt > MAX_ALT_POINTS) ? MAX_ALT_POINTS : int'(alt_cnt);
    r.atten = '0;
    if (nf == 0 || na == 0) begin
      r.stat = STAT_NOT_LOADED;
      return r;
    end
    if (qf < freq_ax[0] || qf > freq_ax[nf-1] ||
        24'(qa) < alt_ax[0] || 24'(qa) > alt_ax[na-1]) begin
      r.stat = STAT_OUTSIDE;
      return r;
    end
    fi = bracket(1'b0, nf, qf);
    ai = bracket(1'b1, na, 24'(qa));
    fn = (fi + 1 < nf) ? fi + 1 : nf - 1;
    an = (ai + 1 < na) ? ai + 1 : na - 1;
    tf = frac(qf, freq_ax[fi], freq_ax[fn]);
    th = frac(24'(qa), alt_ax[ai], alt_ax[an]);
    r0 = blend(grid[fi*na + ai], grid[fi*na + an], th);
    r1 = blend(grid[fn*na + ai], grid[fn*na + an], th);
    r.atten = blend(r0, r1, tf);
    r.stat = STAT_OK;
    return r;
  endfunction

  // track config, predict on input beats, compare on output beats
  always @(posedge clk) begin
    lookup_t got, want;
    if (rst) begin
      freq_cnt <= '0;
      alt_cnt  <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_FREQ_POINTS) freq_cnt <= cfg_data;
        else alt_cnt <= cfg_data[5:0];
      end
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_FREQ: if (entry_index < MAX_FREQ_POINTS) freq_ax[entry_index] = entry_value[23:0];
          KIND_ALT:  if (entry_index < MAX_ALT_POINTS) alt_ax[entry_index] = {8'd0, entry_value[15:0]};
          KIND_CELL: grid[entry_index] = entry_value;
          KIND_QUERY: expected_q.push_back(lookup(query_freq, query_alt));
        endcase
      end
      if (out_valid && !out_stall) begin
        got.atten = attenuation;
        got.stat  = status;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result atten=%h status=%0d", attenuation, status));
        end else begin
          want = expected_q.pop_front();
          if (got.stat !== want.stat)
            report($sformatf("status got %0d want %0d", got.stat, want.stat));
          if (got.atten !== want.atten)
            report($sformatf("attenuation got %h want %h", got.atten, want.atten));
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench
  import gbl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [6:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [10:0] entry_index;
  logic [31:0] entry_value;
  logic [23:0] query_freq;
  logic [15:0] query_alt;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] attenuation;
  logic [1:0]  status;
  int          failures;
  int          pending;

  bit quiet;
  bit hold_req;

  // local axis copies, used to write the axes and to aim queries
  int fa [MAX_FREQ_POINTS];
  int aa [MAX_ALT_POINTS];

  grid_bilinear_lookup u_top (.*);

  gbl_checker u_chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall, .kind,
    .entry_index, .entry_value, .query_freq, .query_alt, .out_valid, .out_stall,
    .attenuation, .status, .failures, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_beat(input logic [1:0] k, input logic [10:0] idx, input logic [31:0] val,
                           input logic [23:0] qf, input logic [15:0] qa);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    entry_index = idx;
    entry_value = val;
    query_freq = qf;
    query_alt = qa;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = 7'(val);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic settle();
    wait (pending == 0);
    repeat (250) @(negedge clk);
  endtask

  function automatic int pick(input int a, input int b, input int top, input int r);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case (r)
      0: return $urandom_range(0, top);
      1: return (lo > 0) ? lo - 1 : 0;
      2: return (hi < top) ? hi + 1 : top;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // one table setting: load axes and grid, then run queries
  task automatic run_setting(input int nf_reg, input int na_reg, input bit noisy, input int nq);
    int nfs, nas, v, r, qf, qa;
    nfs = (nf_reg > MAX_FREQ_POINTS) ? MAX_FREQ_POINTS : nf_reg;
    nas = (na_reg > MAX_ALT_POINTS) ? MAX_ALT_POINTS : na_reg;
    write_reg(CFG_FREQ_POINTS, nf_reg);
    write_reg(CFG_ALT_POINTS, na_reg);
    v = $urandom_range(0, 255);
    for (int i = 0; i < nfs; i++) begin
      if (noisy) fa[i] = $urandom_range(0, 24'hFFFFFF);
      else begin
        if (i > 0 && $urandom_range(0, 5) != 0) v += $urandom_range(1, 16777000 / nfs);
        fa[i] = v;
      end
      send_beat(KIND_FREQ, 11'(i), {8'($urandom), 24'(fa[i])}, 24'($urandom), 16'($urandom));
    end
    v = $urandom_range(0, 255);
    for (int i = 0; i < nas; i++) begin
      if (noisy) aa[i] = $urandom_range(0, 16'hFFFF);
      else begin
        if (i > 0 && $urandom_range(0, 5) != 0) v += $urandom_range(1, 65000 / nas);
        aa[i] = v;
      end
      send_beat(KIND_ALT, 11'(i), {16'($urandom), 16'(aa[i])}, 24'($urandom), 16'($urandom));
    end
    for (int i = 0; i < nfs * nas; i++) begin
      r = $urandom_range(0, 9);
      send_beat(KIND_CELL, 11'(i), (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom,
                24'($urandom), 16'($urandom));
    end
    // writes beyond the axis depths are dropped
    send_beat(KIND_FREQ, 11'($urandom_range(MAX_FREQ_POINTS, 2047)), $urandom, 24'($urandom),
              16'($urandom));
    send_beat(KIND_ALT, 11'($urandom_range(MAX_ALT_POINTS, 2047)), $urandom, 24'($urandom),
              16'($urandom));
    for (int q = 0; q < nq; q++) begin
      if (nfs == 0 || nas == 0) begin
        send_beat(KIND_QUERY, 11'($urandom), $urandom, 24'($urandom), 16'($urandom));
        continue;
      end
      // occasional rewrite of a live entry
      if (q > 6 && $urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 2);
        if (r == 0) begin
          v = $urandom_range(0, nfs - 1);
          fa[v] = $urandom_range(0, 24'hFFFFFF);
          send_beat(KIND_FREQ, 11'(v), 32'(fa[v]), 24'($urandom), 16'($urandom));
        end else if (r == 1) begin
          v = $urandom_range(0, nas - 1);
          aa[v] = $urandom_range(0, 16'hFFFF);
          send_beat(KIND_ALT, 11'(v), 32'(aa[v]), 24'($urandom), 16'($urandom));
        end else begin
          send_beat(KIND_CELL, 11'($urandom_range(0, nfs * nas - 1)), $urandom,
                    24'($urandom), 16'($urandom));
        end
      end
      // corners first, then mostly in-span points
      case (q)
        0: begin qf = fa[0]; qa = aa[0]; end
        1: begin qf = fa[nfs-1]; qa = aa[nas-1]; end
        2: begin qf = 0; qa = 0; end
        3: begin qf = 24'hFFFFFF; qa = 16'hFFFF; end
        4: begin qf = fa[$urandom_range(0, nfs-1)]; qa = aa[$urandom_range(0, nas-1)]; end
        default: begin
          qf = pick(fa[0], fa[nfs-1], 24'hFFFFFF, $urandom_range(0, 12));
          qa = pick(aa[0], aa[nas-1], 16'hFFFF, $urandom_range(0, 12));
          if ($urandom_range(0, 9) == 0) qf = fa[$urandom_range(0, nfs-1)];
        end
      endcase
      send_beat(KIND_QUERY, 11'($urandom), $urandom, 24'(qf), 16'(qa));
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_FREQ_POINTS;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_QUERY;
    entry_index = '0;
    entry_value = '0;
    query_freq = '0;
    query_alt = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // empty table straight after reset
    for (int i = 0; i < 3; i++)
      send_beat(KIND_QUERY, 11'($urandom), $urandom, 24'($urandom), 16'($urandom));
    settle();

    run_setting(3, 0, 1'b0, 4);
    run_setting(0, 5, 1'b0, 4);
    run_setting(1, 1, 1'b0, 12);
    run_setting(2, 2, 1'b0, 20);
    hold_req = 1'b1;
    run_setting(4, 5, 1'b0, 30);
    // counts above the store depths saturate
    run_setting(127, 1, 1'b0, 12);
    run_setting(1, 63, 1'b0, 12);
    run_setting(6, 4, 1'b1, 20);
    quiet = 1'b1;
    run_setting(3, 3, 1'b0, 20);

    if (failures == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gbl_pkg.sv
sv/grid_bilinear_lookup.sv
tb/sv/gbl_checker.sv
tb/sv/testbench.sv
